@@ design/image_header_size_parser_top_defines.svh @@
// ---------------------------------------------------------------------------
// Image header size parser - assertion macros
// Concurrent checks used by the parser top level; empty when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef IMAGE_HEADER_SIZE_PARSER_TOP_DEFINES_SVH
`define IMAGE_HEADER_SIZE_PARSER_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IHSP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ihsp: same-cycle check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IHSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ihsp: next-cycle check failed");
`else
`define IHSP_ASSERT_IMPL(lbl, ante, cons)
`define IHSP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ design/ihsp_pkg.sv @@
// ---------------------------------------------------------------------------
// Image header size parser - package
// Types, signature tables and the reset state of the per-file parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ihsp_pkg;

    // Byte position saturates here; reaching it means the file is long enough.
    localparam int unsigned MinFileLen = 24;
    localparam int unsigned PosW       = 5;

    // Candidate format bits
    localparam int unsigned CandJpeg = 0;
    localparam int unsigned CandGif  = 1;
    localparam int unsigned CandPng  = 2;

    typedef enum logic [1:0] {
        FMT_UNKNOWN = 2'd0,
        FMT_JPEG    = 2'd1,
        FMT_GIF     = 2'd2,
        FMT_PNG     = 2'd3
    } image_format_t;

    // JPEG segment walk
    typedef enum logic [3:0] {
        PH_SIG,
        PH_FF,
        PH_CODE,
        PH_LENH,
        PH_LENL,
        PH_SKIP,
        PH_SOFSKIP,
        PH_HH,
        PH_HL,
        PH_WH,
        PH_WL,
        PH_DONE
    } parse_phase_t;

    typedef struct packed {
        logic [PosW-1:0] pos;
        parse_phase_t    phase;
        logic [2:0]      cand;
        logic [15:0]     skip;
        logic [7:0]      len_hi;
        logic [31:0]     width;
        logic [31:0]     height;
        logic            size_done;
    } parse_state_t;

    typedef struct packed {
        image_format_t format;
        logic          found;
        logic [31:0]   width;
        logic [31:0]   height;
    } parse_result_t;

    localparam parse_state_t ResetState = '{
        pos:       '0,
        phase:     PH_SIG,
        cand:      3'b111,
        skip:      '0,
        len_hi:    '0,
        width:     '0,
        height:    '0,
        size_done: 1'b0
    };

    localparam logic [7:0] PngSig [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                          8'h0D, 8'h0A, 8'h1A, 8'h0A};
    localparam logic [7:0] IhdrTag [4] = '{8'h49, 8'h48, 8'h44, 8'h52};
    localparam logic [7:0] GifTag  [4] = '{8'h47, 8'h49, 8'h46, 8'h00};
    localparam logic [7:0] JpegHead[4] = '{8'hFF, 8'hD8, 8'hFF, 8'hE0};
    localparam logic [7:0] JfifTag [4] = '{8'h4A, 8'h46, 8'h49, 8'h46};

    localparam logic [7:0] MarkerPrefix = 8'hFF;
    localparam logic [15:0] SofHeadSkip = 16'd3;

    // Start-of-frame markers: C0-C3 and C9-CB
    function automatic logic is_sof(input logic [7:0] code);
        logic r;
        r = ((code >= 8'hC0) && (code <= 8'hC3)) || ((code >= 8'hC9) && (code <= 8'hCB));
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/image_header_size_parser_top.sv @@
// ---------------------------------------------------------------------------
// Image header size parser - top level
// Result: registered, so it appears on the master side in the cycle after the
//   transfer of the closing byte (s_axis_tlast high).
// Throughput: one byte per cycle, as the state update is combinational; a new
//   byte is taken in the cycle a waiting result drains, a held result stalls it.
// Reset: rst_n asynchronous, active low; clears parser state and output valid.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "image_header_size_parser_top_defines.svh"

module image_header_size_parser_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Byte stream in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // end_of_file
    // Size result out, one per file
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata    // [1:0] image_format, [2] found,
                                             // [34:3] image_width,
                                             // [66:35] image_height, rest zero
);

    ihsp_pkg::parse_state_t  state_reg;
    ihsp_pkg::parse_state_t  state_next;
    ihsp_pkg::parse_result_t step_res;
    ihsp_pkg::parse_result_t result_reg;
    logic                    out_valid_reg;
    logic                    in_xfer;

    // Input is taken whenever the output register is free or drains now
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    ihsp_step u_step (
        .cur         (state_reg),
        .data_byte   (s_axis_tdata),
        .end_of_file (s_axis_tlast),
        .nxt         (state_next),
        .res         (step_res)
    );

    // Parser state moves one byte per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ihsp_pkg::ResetState;
        else if (in_xfer)
            state_reg <= state_next;
    end

    // Output valid: set on the closing byte, cleared when the result is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer && s_axis_tlast)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer && s_axis_tlast)
            result_reg <= step_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, result_reg.height, result_reg.width,
                            result_reg.found, result_reg.format};

    // A held result blocks the input side
    `IHSP_ASSERT_IMPL(a_stall_blocks_input, out_valid_reg && !m_axis_tready, !s_axis_tready)
    // The closing byte always yields a result next cycle
    `IHSP_ASSERT_NEXT(a_eof_gives_result, in_xfer && s_axis_tlast, out_valid_reg)
    // After the closing byte the parser starts afresh
    `IHSP_ASSERT_NEXT(a_eof_restarts, in_xfer && s_axis_tlast,
        state_reg.pos == '0 && state_reg.cand == 3'b111 && state_reg.size_done == 1'b0)
    // A failed result carries no format and no size
    `IHSP_ASSERT_IMPL(a_failed_is_zero, out_valid_reg && !result_reg.found,
        result_reg.format == ihsp_pkg::FMT_UNKNOWN && result_reg.width == 32'd0 &&
        result_reg.height == 32'd0)

endmodule

`default_nettype wire

@@ design/ihsp_step.sv @@
// ---------------------------------------------------------------------------
// Image header size parser - byte step
// Combinational update of the parser state for one byte, plus the result
// formed when that byte closes the file.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ihsp_step (
    input  wire ihsp_pkg::parse_state_t  cur,
    input  wire logic [7:0]              data_byte,
    input  wire logic                    end_of_file,
    output ihsp_pkg::parse_state_t       nxt,
    output ihsp_pkg::parse_result_t      res
);

    ihsp_pkg::parse_state_t walked;

    // Signature checks, accumulators and the JPEG segment walk
    always_comb
    begin
        logic [ihsp_pkg::PosW-1:0] p;
        logic [4:0]      p6;
        logic [4:0]      p12;
        logic [15:0]     seg_len;
        p       = cur.pos;
        p6      = cur.pos - 5'd6;
        p12     = cur.pos - 5'd12;
        seg_len = {cur.len_hi, data_byte};
        walked  = cur;

        if ((p < 5'd3) && (data_byte != ihsp_pkg::GifTag[p[1:0]]))
            walked.cand[ihsp_pkg::CandGif] = 1'b0;
        if ((p < 5'd8) && (data_byte != ihsp_pkg::PngSig[p[2:0]]))
            walked.cand[ihsp_pkg::CandPng] = 1'b0;
        if ((p >= 5'd12) && (p < 5'd16) && (data_byte != ihsp_pkg::IhdrTag[p12[1:0]]))
            walked.cand[ihsp_pkg::CandPng] = 1'b0;
        if ((p < 5'd4) && (data_byte != ihsp_pkg::JpegHead[p[1:0]]))
            walked.cand[ihsp_pkg::CandJpeg] = 1'b0;
        if ((p >= 5'd6) && (p < 5'd10) && (data_byte != ihsp_pkg::JfifTag[p6[1:0]]))
            walked.cand[ihsp_pkg::CandJpeg] = 1'b0;

        // GIF: little-endian 16-bit width and height at bytes 6-9
        if (walked.cand[ihsp_pkg::CandGif])
        begin
            if (p == 5'd6)
                walked.width = {24'd0, data_byte};
            else if (p == 5'd7)
                walked.width = walked.width | {16'd0, data_byte, 8'd0};
            else if (p == 5'd8)
                walked.height = {24'd0, data_byte};
            else if (p == 5'd9)
            begin
                walked.height    = walked.height | {16'd0, data_byte, 8'd0};
                walked.size_done = 1'b1;
            end
        end

        // PNG: big-endian 32-bit width and height at bytes 16-23
        if (walked.cand[ihsp_pkg::CandPng])
        begin
            if ((p >= 5'd16) && (p < 5'd20))
                walked.width = {walked.width[23:0], data_byte};
            else if ((p >= 5'd20) && (p < 5'd24))
            begin
                walked.height = {walked.height[23:0], data_byte};
                if (p == 5'd23)
                    walked.size_done = 1'b1;
            end
        end

        if (walked.cand[ihsp_pkg::CandJpeg])
        begin
            unique case (cur.phase)
                ihsp_pkg::PH_SIG:
                    if (p >= 5'd1)
                        walked.phase = ihsp_pkg::PH_FF;
                ihsp_pkg::PH_FF:
                    if (data_byte != ihsp_pkg::MarkerPrefix)
                        walked.cand[ihsp_pkg::CandJpeg] = 1'b0;
                    else
                        walked.phase = ihsp_pkg::PH_CODE;
                ihsp_pkg::PH_CODE:
                    if (ihsp_pkg::is_sof(data_byte))
                    begin
                        walked.skip  = ihsp_pkg::SofHeadSkip;
                        walked.phase = ihsp_pkg::PH_SOFSKIP;
                    end
                    else
                        walked.phase = ihsp_pkg::PH_LENH;
                ihsp_pkg::PH_LENH:
                begin
                    walked.len_hi = data_byte;
                    walked.phase  = ihsp_pkg::PH_LENL;
                end
                ihsp_pkg::PH_LENL:
                    if (seg_len < 16'd2)
                        walked.cand[ihsp_pkg::CandJpeg] = 1'b0;
                    else if (seg_len == 16'd2)
                        walked.phase = ihsp_pkg::PH_FF;
                    else
                    begin
                        walked.skip  = seg_len - 16'd2;
                        walked.phase = ihsp_pkg::PH_SKIP;
                    end
                ihsp_pkg::PH_SKIP:
                begin
                    walked.skip = cur.skip - 16'd1;
                    if (cur.skip == 16'd1)
                        walked.phase = ihsp_pkg::PH_FF;
                end
                ihsp_pkg::PH_SOFSKIP:
                begin
                    walked.skip = cur.skip - 16'd1;
                    if (cur.skip == 16'd1)
                        walked.phase = ihsp_pkg::PH_HH;
                end
                ihsp_pkg::PH_HH:
                begin
                    walked.height = {16'd0, data_byte, 8'd0};
                    walked.phase  = ihsp_pkg::PH_HL;
                end
                ihsp_pkg::PH_HL:
                begin
                    walked.height = walked.height | {24'd0, data_byte};
                    walked.phase  = ihsp_pkg::PH_WH;
                end
                ihsp_pkg::PH_WH:
                begin
                    walked.width = {16'd0, data_byte, 8'd0};
                    walked.phase = ihsp_pkg::PH_WL;
                end
                ihsp_pkg::PH_WL:
                begin
                    walked.width     = walked.width | {24'd0, data_byte};
                    walked.size_done = 1'b1;
                    walked.phase     = ihsp_pkg::PH_DONE;
                end
                default:
                    walked.phase = cur.phase;
            endcase
        end

        // Saturating byte count
        if (cur.pos != ihsp_pkg::PosW'(ihsp_pkg::MinFileLen))
            walked.pos = cur.pos + 5'd1;
    end

    // Next state: back to reset after the closing byte
    always_comb
    begin
        if (end_of_file)
            nxt = ihsp_pkg::ResetState;
        else
            nxt = walked;
    end

    // Result for the closing byte
    always_comb
    begin
        ihsp_pkg::image_format_t fmt;
        fmt = ihsp_pkg::FMT_UNKNOWN;
        if ((walked.pos == ihsp_pkg::PosW'(ihsp_pkg::MinFileLen)) && walked.size_done)
        begin
            unique case (walked.cand)
                3'b001:  fmt = ihsp_pkg::FMT_JPEG;
                3'b010:  fmt = ihsp_pkg::FMT_GIF;
                3'b100:  fmt = ihsp_pkg::FMT_PNG;
                default: fmt = ihsp_pkg::FMT_UNKNOWN;
            endcase
        end
        res.format = fmt;
        res.found  = (fmt != ihsp_pkg::FMT_UNKNOWN);
        res.width  = (fmt != ihsp_pkg::FMT_UNKNOWN) ? walked.width  : 32'd0;
        res.height = (fmt != ihsp_pkg::FMT_UNKNOWN) ? walked.height : 32'd0;
    end

endmodule

`default_nettype wire

@@ dv/tb_image_header_size_parser_top.sv @@
// ---------------------------------------------------------------------------
// Image header size parser - testbench
// Sends whole image files byte by byte into the parser: hand-built PNG, GIF
// and JFIF JPEG files at size extremes, damaged and short files, then random
// files (well-formed, truncated, corrupted and plain noise). A behavioural
// model in this file predicts the size report for every file, and each
// transfer on the result side is checked field by field against it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_image_header_size_parser_top;

    localparam int unsigned CycleLimit = 400000;

    // Signature bytes, first file byte in the top byte
    localparam logic [63:0] PngMagic  = 64'h89504E470D0A1A0A;
    localparam logic [31:0] IhdrMagic = 32'h49484452;
    localparam logic [23:0] GifMagic  = 24'h474946;
    localparam logic [31:0] JpegStart = 32'hFFD8FFE0;
    localparam logic [31:0] JfifMagic = 32'h4A464946;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic        s_axis_tlast  = 1'b0;    // end_of_file
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;            // [1:0] image_format, [2] found,
                                          // [34:3] image_width, [66:35] image_height

    image_header_size_parser_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // -----------------------------------------------------------------------
    // Predictor state: one file's worth of parsing, cleared after each file
    // -----------------------------------------------------------------------
    logic [31:0]            byte_pos;
    ihsp_pkg::parse_phase_t walk_phase;
    logic [2:0]             maybe_fmt;     // formats still possible, bit per Cand* index
    logic [16:0]            skip_left;
    logic [7:0]             len_high;
    logic [31:0]            acc_width;
    logic [31:0]            acc_height;
    logic                   dims_done;

    ihsp_pkg::parse_result_t size_reports [$];   // expected reports, oldest first
    logic [7:0]              file_bytes [$];     // file under construction

    bit  idle_on;
    int  errors;
    int  bytes_sent;
    int  files_sent;
    int  reports_checked;
    int  found_count;
    int  cycle_count;
    int  stall_left;

    function automatic logic frame_start_code(input logic [7:0] code);
        return (code >= 8'hC0 && code <= 8'hC3) || (code >= 8'hC9 && code <= 8'hCB);
    endfunction

    function automatic void clear_parser_state();
        byte_pos   = '0;
        walk_phase = ihsp_pkg::PH_SIG;
        maybe_fmt  = 3'b111;
        skip_left  = '0;
        len_high   = '0;
        acc_width  = '0;
        acc_height = '0;
        dims_done  = 1'b0;
    endfunction

    // Advances the predictor by one accepted byte; queues a report on the last
    function automatic void absorb_byte(input logic [7:0] b, input logic last);
        logic [31:0]             p;
        logic [15:0]             seg_len;
        ihsp_pkg::image_format_t fmt;
        ihsp_pkg::parse_result_t rep;
        p = byte_pos;

        // Signature checks knock formats out one by one
        if (p < 3 && b != GifMagic[8*(2-p) +: 8])
            maybe_fmt[ihsp_pkg::CandGif] = 1'b0;
        if (p < 8 && b != PngMagic[8*(7-p) +: 8])
            maybe_fmt[ihsp_pkg::CandPng] = 1'b0;
        if (p >= 12 && p < 16 && b != IhdrMagic[8*(15-p) +: 8])
            maybe_fmt[ihsp_pkg::CandPng] = 1'b0;
        if (p < 4 && b != JpegStart[8*(3-p) +: 8])
            maybe_fmt[ihsp_pkg::CandJpeg] = 1'b0;
        if (p >= 6 && p < 10 && b != JfifMagic[8*(9-p) +: 8])
            maybe_fmt[ihsp_pkg::CandJpeg] = 1'b0;

        // GIF: little-endian 16-bit width then height at bytes 6-9
        if (maybe_fmt[ihsp_pkg::CandGif])
        begin
            case (p)
                6: acc_width  = 32'(b);
                7: acc_width  = acc_width | (32'(b) << 8);
                8: acc_height = 32'(b);
                9:
                begin
                    acc_height = acc_height | (32'(b) << 8);
                    dims_done  = 1'b1;
                end
                default: ;
            endcase
        end

        // PNG: big-endian 32-bit width then height at bytes 16-23
        if (maybe_fmt[ihsp_pkg::CandPng])
        begin
            if (p >= 16 && p < 20)
                acc_width = {acc_width[23:0], b};
            else if (p >= 20 && p < 24)
            begin
                acc_height = {acc_height[23:0], b};
                if (p == 23)
                    dims_done = 1'b1;
            end
        end

        // JPEG: walk the marker segments until a start-of-frame
        if (maybe_fmt[ihsp_pkg::CandJpeg])
        begin
            case (walk_phase)
                ihsp_pkg::PH_SIG:
                    if (p >= 1)
                        walk_phase = ihsp_pkg::PH_FF;
                ihsp_pkg::PH_FF:
                    if (b != 8'hFF)
                        maybe_fmt[ihsp_pkg::CandJpeg] = 1'b0;
                    else
                        walk_phase = ihsp_pkg::PH_CODE;
                ihsp_pkg::PH_CODE:
                    if (frame_start_code(b))
                    begin
                        skip_left  = 17'd3;   // length and precision
                        walk_phase = ihsp_pkg::PH_SOFSKIP;
                    end
                    else
                        walk_phase = ihsp_pkg::PH_LENH;
                ihsp_pkg::PH_LENH:
                begin
                    len_high   = b;
                    walk_phase = ihsp_pkg::PH_LENL;
                end
                ihsp_pkg::PH_LENL:
                begin
                    seg_len = {len_high, b};
                    if (seg_len < 16'd2)
                        maybe_fmt[ihsp_pkg::CandJpeg] = 1'b0;
                    else if (seg_len == 16'd2)
                        walk_phase = ihsp_pkg::PH_FF;
                    else
                    begin
                        skip_left  = 17'(seg_len) - 17'd2;
                        walk_phase = ihsp_pkg::PH_SKIP;
                    end
                end
                ihsp_pkg::PH_SKIP:
                begin
                    skip_left = skip_left - 17'd1;
                    if (skip_left == '0)
                        walk_phase = ihsp_pkg::PH_FF;
                end
                ihsp_pkg::PH_SOFSKIP:
                begin
                    skip_left = skip_left - 17'd1;
                    if (skip_left == '0)
                        walk_phase = ihsp_pkg::PH_HH;
                end
                ihsp_pkg::PH_HH:
                begin
                    acc_height = 32'(b) << 8;
                    walk_phase = ihsp_pkg::PH_HL;
                end
                ihsp_pkg::PH_HL:
                begin
                    acc_height = acc_height | 32'(b);
                    walk_phase = ihsp_pkg::PH_WH;
                end
                ihsp_pkg::PH_WH:
                begin
                    acc_width  = 32'(b) << 8;
                    walk_phase = ihsp_pkg::PH_WL;
                end
                ihsp_pkg::PH_WL:
                begin
                    acc_width  = acc_width | 32'(b);
                    dims_done  = 1'b1;
                    walk_phase = ihsp_pkg::PH_DONE;
                end
                default: ;
            endcase
        end

        if (byte_pos != 32'hFFFF_FFFF)
            byte_pos = byte_pos + 32'd1;

        if (last)
        begin
            fmt = ihsp_pkg::FMT_UNKNOWN;
            if (byte_pos >= ihsp_pkg::MinFileLen && dims_done)
            begin
                if (maybe_fmt == (3'b001 << ihsp_pkg::CandJpeg))
                    fmt = ihsp_pkg::FMT_JPEG;
                else if (maybe_fmt == (3'b001 << ihsp_pkg::CandGif))
                    fmt = ihsp_pkg::FMT_GIF;
                else if (maybe_fmt == (3'b001 << ihsp_pkg::CandPng))
                    fmt = ihsp_pkg::FMT_PNG;
            end
            rep.format = fmt;
            rep.found  = (fmt != ihsp_pkg::FMT_UNKNOWN);
            rep.width  = rep.found ? acc_width  : 32'd0;
            rep.height = rep.found ? acc_height : 32'd0;
            size_reports.push_back(rep);
            clear_parser_state();
        end
    endfunction

    // -----------------------------------------------------------------------
    // File builders: append to file_bytes
    // -----------------------------------------------------------------------
    function automatic void add_random(input int n);
        repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_be16(input logic [15:0] v);
        file_bytes.push_back(v[15:8]);
        file_bytes.push_back(v[7:0]);
    endfunction

    function automatic void pad_to(input int min_len);
        while (file_bytes.size() < min_len)
            file_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // 0, all ones, or random within the given width
    function automatic logic [31:0] pick_dim(input int bits);
        logic [31:0] mask;
        mask = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return mask;
            default: return $urandom() & mask;
        endcase
    endfunction

    function automatic void make_png(input logic [31:0] w, input logic [31:0] h, input int tail);
        for (int i = 7; i >= 0; i--)
            file_bytes.push_back(PngMagic[8*i +: 8]);
        add_be16(16'h0000);
        add_be16(16'h000D);
        add_be16(IhdrMagic[31:16]);
        add_be16(IhdrMagic[15:0]);
        add_be16(w[31:16]);
        add_be16(w[15:0]);
        add_be16(h[31:16]);
        add_be16(h[15:0]);
        add_random(tail);
    endfunction

    function automatic void make_gif(input logic [15:0] w, input logic [15:0] h,
                                     input int min_len, input int tail);
        file_bytes.push_back(GifMagic[23:16]);
        file_bytes.push_back(GifMagic[15:8]);
        file_bytes.push_back(GifMagic[7:0]);
        file_bytes.push_back(8'h38);   // "89a"
        file_bytes.push_back(8'h39);
        file_bytes.push_back(8'h61);
        file_bytes.push_back(w[7:0]);
        file_bytes.push_back(w[15:8]);
        file_bytes.push_back(h[7:0]);
        file_bytes.push_back(h[15:8]);
        pad_to(min_len);
        add_random(tail);
    endfunction

    // SOI, APP0 marker and length, "JFIF", then the rest of the APP0 body
    function automatic void jpeg_head(input int app_len);
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(JpegStart[8*i +: 8]);
        add_be16(16'(app_len));
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(JfifMagic[8*i +: 8]);
        if (app_len > 6)
            add_random(app_len - 6);
    endfunction

    function automatic void jpeg_segment(input logic [7:0] code, input int seg_len);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(code);
        add_be16(16'(seg_len));
        if (seg_len > 2)
            add_random(seg_len - 2);
    endfunction

    function automatic void jpeg_sof(input logic [7:0] code, input logic [15:0] h,
                                     input logic [15:0] w);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(code);
        add_be16(16'd17);
        file_bytes.push_back(8'd8);
        add_be16(h);
        add_be16(w);
    endfunction

    function automatic logic [7:0] random_sof();
        int v;
        v = $urandom_range(0, 6);
        return (v < 4) ? 8'(8'hC0 + v) : 8'(8'hC9 + v - 4);
    endfunction

    function automatic logic [7:0] random_plain_code();
        logic [7:0] c;
        if ($urandom_range(0, 7) == 0)
            return 8'hFF;   // fill byte, walked as an ordinary segment
        do
            c = 8'($urandom_range(0, 255));
        while (frame_start_code(c));
        return c;
    endfunction

    function automatic void make_jpeg(input int app_len, input int n_segs,
                                      input logic [7:0] sof, input logic [15:0] h,
                                      input logic [15:0] w, input int min_len,
                                      input int tail);
        int seg_len;
        jpeg_head(app_len);
        repeat (n_segs)
        begin
            seg_len = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 300)
                                                   : $urandom_range(2, 20);
            jpeg_segment(random_plain_code(), seg_len);
        end
        jpeg_sof(sof, h, w);
        pad_to(min_len);
        add_random(tail);
    endfunction

    function automatic void cut_to(input int n);
        while (file_bytes.size() > n)
            void'(file_bytes.pop_back());
    endfunction

    // -----------------------------------------------------------------------
    // Byte source: one file per call, tlast on its final byte
    // -----------------------------------------------------------------------
    task automatic send_file();
        bit gaps;
        bit closing;
        gaps = idle_on && ($urandom_range(0, 2) != 0);
        foreach (file_bytes[i])
        begin
            closing = (i == file_bytes.size() - 1);
            if (gaps && $urandom_range(0, 5) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= file_bytes[i];
            s_axis_tlast  <= closing;
            do
                @(posedge clk);
            while (!s_axis_tready);
            absorb_byte(file_bytes[i], closing);
            bytes_sent++;
            @(negedge clk);
        end
        files_sent++;
        file_bytes.delete();
    endtask

    // -----------------------------------------------------------------------
    // Result sink: random back-pressure bursts while idle_on is set
    // -----------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 18);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Checks every result transfer against the oldest expected report
    always @(posedge clk)
    begin : check_reports
        ihsp_pkg::parse_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (size_reports.size() == 0)
            begin
                $display("%0t: result with none expected, tdata %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = size_reports.pop_front();
                reports_checked++;
                if (want.found)
                    found_count++;
                if (m_axis_tdata[1:0] !== want.format)
                begin
                    $display("%0t: image_format expected %0d actual %0d",
                             $time, want.format, m_axis_tdata[1:0]);
                    errors++;
                end
                if (m_axis_tdata[2] !== want.found)
                begin
                    $display("%0t: found expected %0d actual %0d",
                             $time, want.found, m_axis_tdata[2]);
                    errors++;
                end
                if (m_axis_tdata[34:3] !== want.width)
                begin
                    $display("%0t: image_width expected %h actual %h",
                             $time, want.width, m_axis_tdata[34:3]);
                    errors++;
                end
                if (m_axis_tdata[66:35] !== want.height)
                begin
                    $display("%0t: image_height expected %h actual %h",
                             $time, want.height, m_axis_tdata[66:35]);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("%0t: timed out with %0d reports outstanding", $time, size_reports.size());
            $display("FAIL");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Good files of each format at the size extremes, every SOF code class
    task automatic test_reference_files();
        make_png(32'hFFFF_FFFF, 32'h0000_0000, 0);
        send_file();
        make_png(32'h0000_0001, 32'h8000_0000, 3);
        send_file();
        make_gif(16'hFFFF, 16'h0001, 24, 0);
        send_file();
        make_gif(16'h0000, 16'hFFFF, 30, 2);
        send_file();
        // APP0, then non-SOF codes next to the SOF ranges, a bare length of 2
        jpeg_head(16);
        jpeg_segment(8'hC4, 4);
        jpeg_segment(8'hC8, 2);
        jpeg_segment(8'hCC, 3);
        jpeg_sof(8'hC0, 16'hFFFF, 16'h0000);
        send_file();
        make_jpeg(16, 1, 8'hC3, 16'h0000, 16'hFFFF, 24, 1);
        send_file();
        make_jpeg(16, 0, 8'hC9, 16'h1234, 16'h8001, 24, 0);
        send_file();
        make_jpeg(20, 2, 8'hCB, 16'h00FF, 16'hFF00, 24, 4);
        send_file();
    endtask

    // Short, truncated and damaged files, fill bytes and trailing data
    task automatic test_malformed_streams();
        // Single-byte file
        file_bytes.push_back(8'hFF);
        send_file();
        // Good GIF header but only 23 bytes long
        make_gif(16'h0102, 16'h0304, 23, 0);
        send_file();
        // JPEG that completes its sizes within 21 bytes
        make_jpeg(8, 0, 8'hC0, 16'h0040, 16'h0080, 0, 0);
        send_file();
        // PNG cut short of its height
        make_png(32'h0000_0100, 32'h0000_0200, 0);
        cut_to(22);
        send_file();
        // PNG with a damaged IHDR tag
        make_png(32'h0000_0100, 32'h0000_0200, 0);
        file_bytes[13] = 8'h00;
        send_file();
        // APP1 where APP0 is required, then a damaged JFIF tag
        make_jpeg(16, 0, 8'hC0, 16'h0010, 16'h0020, 24, 0);
        file_bytes[3] = 8'hE1;
        send_file();
        make_jpeg(16, 0, 8'hC0, 16'h0010, 16'h0020, 24, 0);
        file_bytes[8] = 8'h58;
        send_file();
        // Marker prefix missing after APP0
        jpeg_head(16);
        file_bytes.push_back(8'h00);
        jpeg_sof(8'hC0, 16'h0010, 16'h0020);
        send_file();
        // Segment lengths of one and zero
        jpeg_head(16);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'hE2);
        add_be16(16'h0001);
        jpeg_sof(8'hC0, 16'h0010, 16'h0020);
        send_file();
        jpeg_head(16);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'hE2);
        add_be16(16'h0000);
        jpeg_sof(8'hC0, 16'h0010, 16'h0020);
        send_file();
        // Fill-byte marker code walked as a plain segment
        jpeg_head(16);
        jpeg_segment(8'hFF, 5);
        jpeg_sof(8'hC2, 16'h0777, 16'h0888);
        add_random(6);
        send_file();
        // Long segment that the file never finishes
        jpeg_head(16);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'hE1);
        add_be16(16'h1234);
        add_random(20);
        send_file();
        // File ends after the height but before the width
        jpeg_head(16);
        jpeg_sof(8'hC1, 16'h0100, 16'h0200);
        cut_to(file_bytes.size() - 2);
        send_file();
    endtask

    // Random files until both the byte budget and the file count are met
    task automatic test_random_files(input int byte_budget, input int min_files);
        int first_byte;
        int first_file;
        int kind;
        first_byte = bytes_sent;
        first_file = files_sent;
        while (bytes_sent - first_byte < byte_budget || files_sent - first_file < min_files)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 8)
                add_random($urandom_range(1, 40));
            else
            begin
                case ($urandom_range(0, 3))
                    0: make_png(pick_dim(32), pick_dim(32), $urandom_range(0, 4));
                    1: make_gif(16'(pick_dim(16)), 16'(pick_dim(16)), 24, $urandom_range(0, 4));
                    default:
                        make_jpeg(($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : 16,
                                  $urandom_range(0, 3), random_sof(),
                                  16'(pick_dim(16)), 16'(pick_dim(16)),
                                  24, $urandom_range(0, 4));
                endcase
                if (kind < 22)
                    cut_to($urandom_range(1, file_bytes.size()));
                else if (kind < 36)
                    file_bytes[$urandom_range(0, file_bytes.size() - 1)] =
                        8'($urandom_range(0, 255));
            end
            send_file();
        end
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial
    begin
        clear_parser_state();
        idle_on = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reference_files();
        test_malformed_streams();
        test_random_files(110, 4);
        // Last stretch at full rate on both sides
        idle_on = 1'b0;
        test_random_files(50, 2);
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        while (size_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d files (%0d bytes): PNG, GIF, JPEG, damaged and noise files",
                 files_sent, bytes_sent);
        $display("Checked %0d size reports, %0d with sizes found, %0d mismatches",
                 reports_checked, found_count, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/ihsp_pkg.sv
design/ihsp_step.sv
design/image_header_size_parser_top.sv
dv/tb_image_header_size_parser_top.sv
